// ===== sv/i2c_seq_pkg.sv =====
`default_nettype none

package i2c_seq_pkg;

    // Write byte store
    localparam int unsigned BUFFER_DEPTH = 256;
    localparam int unsigned BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // Input word kinds (carried on s_tuser)
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DONE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    // Result word kinds (carried on m_tuser)
    localparam logic [2:0] ACT_START    = 3'd0;
    localparam logic [2:0] ACT_SEND     = 3'd1;
    localparam logic [2:0] ACT_RX_ACK   = 3'd2;
    localparam logic [2:0] ACT_RX_NACK  = 3'd3;
    localparam logic [2:0] ACT_STOP     = 3'd4;
    localparam logic [2:0] ACT_RECEIVED = 3'd5;
    localparam logic [2:0] ACT_FINISHED = 3'd6;

    // Result codes
    localparam logic [3:0] RC_OK         = 4'd0;
    localparam logic [3:0] RC_START_ERR  = 4'd7;
    localparam logic [3:0] RC_ADDRW_ERR  = 4'd8;
    localparam logic [3:0] RC_DATATX_ERR = 4'd9;
    localparam logic [3:0] RC_ADDRR_ERR  = 4'd10;

    // Engine status codes
    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RPTSTART = 8'h10;
    localparam logic [7:0] ST_ADDRW    = 8'h18;
    localparam logic [7:0] ST_DATATX   = 8'h28;
    localparam logic [7:0] ST_ADDRR    = 8'h40;
    localparam logic [7:0] ST_DATARX   = 8'h50;

    // Result queue
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = 2;

    // One record per accepted word that yields results: up to two leading words,
    // then an optional stop and finished pair.
    typedef struct packed {
        logic [1:0] lead_cnt;
        logic [2:0] lead0_act;
        logic [7:0] lead0_data;
        logic [2:0] lead1_act;
        logic       fin;
        logic [3:0] fin_code;
        logic [7:0] fin_count;
        logic [7:0] fin_raw;
    } rec_t;

endpackage

`default_nettype wire

// ===== sv/i2c_master_transaction_sequencer.sv =====
// Runs one I2C write-then-read transaction over a byte-level bus engine. Input
// words (begin, engine completion, millisecond tick, write byte load) are taken
// one per clock while the four-record result queue has room; each word yields
// zero to three result words, which leave on the master side at one per clock
// while m_tready is high. The write bytes sit in a 256 x 8 memory with a
// registered read port: the byte to send next is fetched ahead into the read
// register, and a load to that entry is bypassed into the read register. The
// memory is not cleared after reset; only loaded entries may be sent.
`default_nettype none

module i2c_master_transaction_sequencer (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: target_address[6:0], write_count[14:7], read_count[22:15],
    // timeout_limit[38:23], bus_status[46:39], read_byte[54:47],
    // load_index[62:55], load_byte[70:63], zero[71]
    input  wire  [71:0] s_tdata,
    // tuser: opcode[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: data_byte[7:0], result_code[11:8], received_count[19:12],
    // raw_status[27:20], zero[31:28]
    output logic [31:0] m_tdata,
    // tuser: action[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import i2c_seq_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START    = 3'd1;
    localparam logic [2:0] PH_ADDRW    = 3'd2;
    localparam logic [2:0] PH_DATATX   = 3'd3;
    localparam logic [2:0] PH_RPTSTART = 3'd4;
    localparam logic [2:0] PH_ADDRR    = 3'd5;
    localparam logic [2:0] PH_DATARX   = 3'd6;

    logic [6:0]  in_addr;
    logic [7:0]  in_wcount, in_rcount, in_status, in_rbyte, in_lidx, in_lbyte;
    logic [15:0] in_timeout;

    assign in_addr    = s_tdata[6:0];
    assign in_wcount  = s_tdata[14:7];
    assign in_rcount  = s_tdata[22:15];
    assign in_timeout = s_tdata[38:23];
    assign in_status  = s_tdata[46:39];
    assign in_rbyte   = s_tdata[54:47];
    assign in_lidx    = s_tdata[62:55];
    assign in_lbyte   = s_tdata[70:63];

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  wpos_reg, wpos_next;
    logic [7:0]  rpos_reg, rpos_next;
    logic [7:0]  wtotal_reg, wtotal_next;
    logic [7:0]  rtotal_reg, rtotal_next;
    logic [6:0]  addr_reg, addr_next;
    logic [15:0] tleft_reg, tleft_next;
    logic [7:0]  status_reg, status_next;

    logic [7:0]  wbuf_mem [BUFFER_DEPTH];
    logic [7:0]  wbuf_rdata_reg;
    logic [7:0]  fetch_pos;
    logic        load_we;
    logic [7:0]  send_byte;

    rec_t        rec_q [RQ_DEPTH];
    rec_t        rec, head;
    logic [RQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RQ_AW:0]   cnt_reg;
    logic [1:0]  sub_reg;
    logic        in_acc, push, pop, word_last;
    logic [7:0]  st_m;
    logic [7:0]  rp_inc;
    logic [2:0]  total;

    assign s_tready = (cnt_reg != RQ_AW'(0) + (RQ_AW+1)'(RQ_DEPTH));
    assign in_acc   = s_tvalid && s_tready;
    assign st_m     = in_status & ST_MASK;
    assign rp_inc   = rpos_reg + 8'd1;
    assign load_we  = in_acc && (s_tuser == OP_LOAD)
                      && ({1'b0, in_lidx} < 9'(BUFFER_DEPTH));

    // The entry held in the read register is the byte the next send needs.
    assign send_byte = ({1'b0, wpos_reg} + ((phase_reg == PH_DATATX) ? 9'd1 : 9'd0)
                        < 9'(BUFFER_DEPTH)) ? wbuf_rdata_reg : 8'h00;

    always_comb begin
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        rpos_next   = rpos_reg;
        wtotal_next = wtotal_reg;
        rtotal_next = rtotal_reg;
        addr_next   = addr_reg;
        tleft_next  = tleft_reg;
        status_next = status_reg;
        rec         = '0;
        if (in_acc) begin
            case (s_tuser)
                OP_BEGIN: begin
                    if (phase_reg == PH_IDLE) begin
                        addr_next     = in_addr;
                        wtotal_next   = in_wcount;
                        rtotal_next   = in_rcount;
                        tleft_next    = in_timeout;
                        wpos_next     = 8'd0;
                        rpos_next     = 8'd0;
                        status_next   = 8'd0;
                        phase_next    = PH_START;
                        rec.lead_cnt  = 2'd1;
                        rec.lead0_act = ACT_START;
                    end
                end
                OP_DONE: begin
                    if (phase_reg != PH_IDLE) begin
                        status_next = in_status;
                        case (phase_reg)
                            PH_START: begin
                                if (st_m != ST_START) begin
                                    rec.fin = 1'b1;
                                    rec.fin_code = RC_START_ERR;
                                end else if (wtotal_reg != 8'd0) begin
                                    phase_next     = PH_ADDRW;
                                    rec.lead_cnt   = 2'd1;
                                    rec.lead0_act  = ACT_SEND;
                                    rec.lead0_data = {addr_reg, 1'b0};
                                end else if (rtotal_reg != 8'd0) begin
                                    phase_next     = PH_ADDRR;
                                    rec.lead_cnt   = 2'd1;
                                    rec.lead0_act  = ACT_SEND;
                                    rec.lead0_data = {addr_reg, 1'b1};
                                end else begin
                                    rec.fin = 1'b1;
                                end
                            end
                            PH_ADDRW: begin
                                if (st_m != ST_ADDRW) begin
                                    rec.fin = 1'b1;
                                    rec.fin_code = RC_ADDRW_ERR;
                                end else begin
                                    phase_next     = PH_DATATX;
                                    rec.lead_cnt   = 2'd1;
                                    rec.lead0_act  = ACT_SEND;
                                    rec.lead0_data = send_byte;
                                end
                            end
                            PH_DATATX: begin
                                if (st_m != ST_DATATX) begin
                                    rec.fin = 1'b1;
                                    rec.fin_code = RC_DATATX_ERR;
                                end else begin
                                    wpos_next = wpos_reg + 8'd1;
                                    if (wpos_next != 8'd0 && wpos_next < wtotal_reg) begin
                                        rec.lead_cnt   = 2'd1;
                                        rec.lead0_act  = ACT_SEND;
                                        rec.lead0_data = send_byte;
                                    end else if (rtotal_reg != 8'd0) begin
                                        phase_next    = PH_RPTSTART;
                                        rec.lead_cnt  = 2'd1;
                                        rec.lead0_act = ACT_START;
                                    end else begin
                                        rec.fin = 1'b1;
                                    end
                                end
                            end
                            PH_RPTSTART: begin
                                if (st_m != ST_RPTSTART) begin
                                    rec.fin = 1'b1;
                                    rec.fin_code = RC_START_ERR;
                                end else begin
                                    phase_next     = PH_ADDRR;
                                    rec.lead_cnt   = 2'd1;
                                    rec.lead0_act  = ACT_SEND;
                                    rec.lead0_data = {addr_reg, 1'b1};
                                end
                            end
                            PH_ADDRR: begin
                                if (st_m != ST_ADDRR) begin
                                    rec.fin = 1'b1;
                                    rec.fin_code = RC_ADDRR_ERR;
                                end else begin
                                    phase_next    = PH_DATARX;
                                    rec.lead_cnt  = 2'd1;
                                    rec.lead0_act = ({1'b0, rpos_reg} + 9'd1 >= {1'b0, rtotal_reg})
                                                    ? ACT_RX_NACK : ACT_RX_ACK;
                                end
                            end
                            PH_DATARX: begin
                                rec.lead0_act  = ACT_RECEIVED;
                                rec.lead0_data = in_rbyte;
                                rpos_next      = rp_inc;
                                if (st_m != ST_DATARX || rp_inc >= rtotal_reg) begin
                                    rec.lead_cnt = 2'd1;
                                    rec.fin      = 1'b1;
                                end else begin
                                    rec.lead_cnt  = 2'd2;
                                    rec.lead1_act = ({1'b0, rp_inc} + 9'd1 >= {1'b0, rtotal_reg})
                                                    ? ACT_RX_NACK : ACT_RX_ACK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        if (tleft_reg <= 16'd1) begin
                            tleft_next   = 16'd0;
                            rec.fin      = 1'b1;
                            rec.fin_code = {1'b0, phase_reg};
                        end else begin
                            tleft_next = tleft_reg - 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (rec.fin) begin
            phase_next    = PH_IDLE;
            rec.fin_count = rpos_next;
            rec.fin_raw   = (rec.fin_code != RC_OK) ? status_next : 8'd0;
        end
    end

    // Fetch address follows the next state so that the read register always
    // holds the byte the following send would use.
    assign fetch_pos = wpos_next + ((phase_next == PH_DATATX) ? 8'd1 : 8'd0);

    always_ff @(posedge aclk) begin
        if (load_we) begin
            wbuf_mem[in_lidx[BUF_AW-1:0]] <= in_lbyte;
        end
        if (load_we && in_lidx == fetch_pos) begin
            wbuf_rdata_reg <= in_lbyte;
        end else begin
            wbuf_rdata_reg <= wbuf_mem[fetch_pos[BUF_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            wpos_reg   <= 8'd0;
            rpos_reg   <= 8'd0;
            wtotal_reg <= 8'd0;
            rtotal_reg <= 8'd0;
            addr_reg   <= 7'd0;
            tleft_reg  <= 16'd0;
            status_reg <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            rpos_reg   <= rpos_next;
            wtotal_reg <= wtotal_next;
            rtotal_reg <= rtotal_next;
            addr_reg   <= addr_next;
            tleft_reg  <= tleft_next;
            status_reg <= status_next;
        end
    end

    // Result queue and word expansion
    assign push = in_acc && (rec.lead_cnt != 2'd0 || rec.fin);
    assign head = rec_q[rd_ptr_reg];
    assign total = {1'b0, head.lead_cnt} + (head.fin ? 3'd2 : 3'd0);
    assign word_last = ({1'b0, sub_reg} + 3'd1 == total);
    assign m_tvalid = (cnt_reg != '0);
    assign pop = m_tvalid && m_tready && word_last;
    assign m_tlast = word_last;

    always_comb begin
        m_tuser = ACT_FINISHED;
        m_tdata = '0;
        if (sub_reg < head.lead_cnt) begin
            if (sub_reg == 2'd0) begin
                m_tuser      = head.lead0_act;
                m_tdata[7:0] = head.lead0_data;
            end else begin
                m_tuser = head.lead1_act;
            end
        end else if (sub_reg == head.lead_cnt) begin
            m_tuser = ACT_STOP;
        end else begin
            m_tdata[11:8]  = head.fin_code;
            m_tdata[19:12] = head.fin_count;
            m_tdata[27:20] = head.fin_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            rec_q[wr_ptr_reg] <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + RQ_AW'(1);
            end
            if (m_tvalid && m_tready) begin
                if (word_last) begin
                    rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
                    sub_reg    <= 2'd0;
                end else begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end
            cnt_reg <= cnt_reg + (RQ_AW+1)'(push) - (RQ_AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2c_seq_checker.sv =====
`default_nettype none

module i2c_seq_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);
    import i2c_seq_pkg::*;

    // A word waiting on the result side stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // The finished word always closes the results of its input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_FINISHED |-> m_tlast)
        else $error("finished word without tlast");

    // Stop is always followed by the finished word of the same group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == ACT_STOP |=>
            m_tvalid && m_tuser == ACT_FINISHED)
        else $error("stop not followed by finished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_STOP |-> !m_tlast)
        else $error("stop marked as last word");

    // The result queue starts empty, so nothing is offered in the first cycle
    // after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word straight after reset");

endmodule

bind i2c_master_transaction_sequencer i2c_seq_checker u_i2c_seq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
